// File: rtl/core/box_pair_overlap_test_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box pair overlap test core
// Shared concurrent assertion forms, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef BOX_PAIR_OVERLAP_TEST_CORE_ASSERT_SVH
`define BOX_PAIR_OVERLAP_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define BPOT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPOT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bpot_pkg.sv
// ----------------------------------------------------------------------------
// bpot_pkg
// Widths, stage types and helper functions for the box pair overlap test.
// ----------------------------------------------------------------------------
package bpot_pkg;

   localparam int POS_W      = 24;
   localparam int TRIG_W     = 16;
   localparam int EXT_W      = 23;
   localparam int OVL_W      = 26;
   localparam int FRAC_SHIFT = 14;
   localparam int NUM_STAGES = 6;
   localparam int NUM_AXES   = 4;

   localparam int BOX_W      = 2 * POS_W + 2 * TRIG_W + 2 * EXT_W;
   localparam int REQ_DATA_W = ((2 * BOX_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 + 2 * OVL_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   localparam int DIFF_W     = POS_W + 1;
   localparam int SQ_W       = 2 * TRIG_W;
   localparam int DOT_W      = SQ_W;
   localparam int CPROD_W    = TRIG_W + DIFF_W;
   localparam int DIST_W     = CPROD_W;
   localparam int BPROD_W    = TRIG_W + EXT_W;
   localparam int BEXT_W     = BPROD_W + 1;
   localparam int EPROD_W    = DOT_W + EXT_W;
   localparam int ESUM_W     = EPROD_W + 2;
   localparam int BOUND_W    = BEXT_W + 2;
   localparam int OVL_RAW_W  = BOUND_W + 1;
   localparam int RND_W      = OVL_RAW_W + 1;
   localparam int QUO_W      = RND_W - FRAC_SHIFT;

   localparam logic signed [QUO_W-1:0] OVL_MAX = QUO_W'(33554431);
   localparam logic signed [QUO_W-1:0] OVL_MIN = -QUO_W'(33554432);
   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (FRAC_SHIFT - 1);

   typedef struct packed {
      logic signed [POS_W-1:0]  cx;
      logic signed [POS_W-1:0]  cy;
      logic signed [TRIG_W-1:0] cosine;
      logic signed [TRIG_W-1:0] sine;
      logic [EXT_W-1:0]         hw;
      logic [EXT_W-1:0]         hh;
   } box_type;

   // trig products, center deltas, magnitudes
   typedef struct packed {
      logic signed [SQ_W-1:0]   sq_ac;
      logic signed [SQ_W-1:0]   sq_as;
      logic signed [SQ_W-1:0]   sq_bc;
      logic signed [SQ_W-1:0]   sq_bs;
      logic signed [SQ_W-1:0]   pr_acbc;
      logic signed [SQ_W-1:0]   pr_asbs;
      logic signed [SQ_W-1:0]   pr_acbs;
      logic signed [SQ_W-1:0]   pr_asbc;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [TRIG_W-1:0] a_cos;
      logic signed [TRIG_W-1:0] a_sin;
      logic signed [TRIG_W-1:0] b_cos;
      logic signed [TRIG_W-1:0] b_sin;
      logic [TRIG_W-1:0]        a_cos_mag;
      logic [TRIG_W-1:0]        a_sin_mag;
      logic [TRIG_W-1:0]        b_cos_mag;
      logic [TRIG_W-1:0]        b_sin_mag;
      logic [EXT_W-1:0]         a_hw;
      logic [EXT_W-1:0]         a_hh;
      logic [EXT_W-1:0]         b_hw;
      logic [EXT_W-1:0]         b_hh;
      logic signed [POS_W-1:0]  a_cx;
      logic signed [POS_W-1:0]  a_cy;
      logic signed [POS_W-1:0]  b_cx;
      logic signed [POS_W-1:0]  b_cy;
   } s1_type;

   // axis dot magnitudes, center projections, bounding box products
   typedef struct packed {
      logic [DOT_W-1:0]          a_norm;
      logic [DOT_W-1:0]          b_norm;
      logic [DOT_W-1:0]          dot_p;
      logic [DOT_W-1:0]          dot_q;
      logic signed [CPROD_W-1:0] cp_ac_dx;
      logic signed [CPROD_W-1:0] cp_as_dy;
      logic signed [CPROD_W-1:0] cp_ac_dy;
      logic signed [CPROD_W-1:0] cp_as_dx;
      logic signed [CPROD_W-1:0] cp_bc_dx;
      logic signed [CPROD_W-1:0] cp_bs_dy;
      logic signed [CPROD_W-1:0] cp_bc_dy;
      logic signed [CPROD_W-1:0] cp_bs_dx;
      logic [BPROD_W-1:0]        bp_a_cw;
      logic [BPROD_W-1:0]        bp_a_sh;
      logic [BPROD_W-1:0]        bp_a_sw;
      logic [BPROD_W-1:0]        bp_a_ch;
      logic [BPROD_W-1:0]        bp_b_cw;
      logic [BPROD_W-1:0]        bp_b_sh;
      logic [BPROD_W-1:0]        bp_b_sw;
      logic [BPROD_W-1:0]        bp_b_ch;
      logic [EXT_W-1:0]          a_hw;
      logic [EXT_W-1:0]          a_hh;
      logic [EXT_W-1:0]          b_hw;
      logic [EXT_W-1:0]          b_hh;
      logic signed [POS_W-1:0]   a_cx;
      logic signed [POS_W-1:0]   a_cy;
      logic signed [POS_W-1:0]   b_cx;
      logic signed [POS_W-1:0]   b_cy;
   } s2_type;

   // projected extent products, center distances, bounding extents
   typedef struct packed {
      logic [EPROD_W-1:0]      e_ar_a;
      logic [EPROD_W-1:0]      e_ar_bw;
      logic [EPROD_W-1:0]      e_ar_bh;
      logic [EPROD_W-1:0]      e_au_a;
      logic [EPROD_W-1:0]      e_au_bw;
      logic [EPROD_W-1:0]      e_au_bh;
      logic [EPROD_W-1:0]      e_br_aw;
      logic [EPROD_W-1:0]      e_br_ah;
      logic [EPROD_W-1:0]      e_br_b;
      logic [EPROD_W-1:0]      e_bu_aw;
      logic [EPROD_W-1:0]      e_bu_ah;
      logic [EPROD_W-1:0]      e_bu_b;
      logic [NUM_AXES-1:0][DIST_W-1:0] ctr_dist;
      logic [BEXT_W-1:0]       a_ext_x;
      logic [BEXT_W-1:0]       a_ext_y;
      logic [BEXT_W-1:0]       b_ext_x;
      logic [BEXT_W-1:0]       b_ext_y;
      logic signed [POS_W-1:0] a_cx;
      logic signed [POS_W-1:0] a_cy;
      logic signed [POS_W-1:0] b_cx;
      logic signed [POS_W-1:0] b_cy;
   } s3_type;

   // per-axis reach and distance, world bounds
   typedef struct packed {
      logic [NUM_AXES-1:0][DIST_W-1:0] ctr_dist;
      logic [NUM_AXES-1:0][ESUM_W-1:0] reach;
      logic signed [BOUND_W-1:0] a_right;
      logic signed [BOUND_W-1:0] a_left;
      logic signed [BOUND_W-1:0] a_top;
      logic signed [BOUND_W-1:0] a_bottom;
      logic signed [BOUND_W-1:0] b_right;
      logic signed [BOUND_W-1:0] b_left;
      logic signed [BOUND_W-1:0] b_top;
      logic signed [BOUND_W-1:0] b_bottom;
   } s4_type;

   typedef struct packed {
      logic [NUM_AXES-1:0]         sep;
      logic signed [OVL_RAW_W-1:0] ovl_x;
      logic signed [OVL_RAW_W-1:0] ovl_y;
   } s5_type;

   typedef struct packed {
      logic                    oriented_hit;
      logic                    aligned_hit;
      logic signed [OVL_W-1:0] overlap_x;
      logic signed [OVL_W-1:0] overlap_y;
   } s6_type;

   function automatic box_type unpack_box(logic [BOX_W-1:0] v);
      box_type b;
      b.cx     = v[23:0];
      b.cy     = v[47:24];
      b.cosine = v[63:48];
      b.sine   = v[79:64];
      b.hw     = v[102:80];
      b.hh     = v[125:103];
      return b;
   endfunction

   function automatic logic [TRIG_W-1:0] mag_trig(logic signed [TRIG_W-1:0] v);
      logic [TRIG_W-1:0] n;
      n = ~v + TRIG_W'(1);
      return v[TRIG_W-1] ? n : v;
   endfunction

   function automatic logic [DOT_W-1:0] mag_dot(logic signed [DOT_W:0] v);
      logic signed [DOT_W:0] n;
      n = -v;
      return v[DOT_W] ? n[DOT_W-1:0] : v[DOT_W-1:0];
   endfunction

   function automatic logic [DIST_W-1:0] mag_dist(logic signed [DIST_W:0] v);
      logic signed [DIST_W:0] n;
      n = -v;
      return v[DIST_W] ? n[DIST_W-1:0] : v[DIST_W-1:0];
   endfunction

   // round to nearest, ties up (floor of v + half), then clamp
   function automatic logic signed [OVL_W-1:0] round_sat(logic signed [OVL_RAW_W-1:0] v);
      logic signed [RND_W-1:0] t;
      logic signed [QUO_W-1:0] q;
      t = RND_W'(v) + RND_HALF;
      q = t[RND_W-1:FRAC_SHIFT];
      if (q > OVL_MAX) begin
         q = OVL_MAX;
      end else if (q < OVL_MIN) begin
         q = OVL_MIN;
      end
      return q[OVL_W-1:0];
   endfunction

endpackage

// File: rtl/core/box_pair_overlap_test_core.sv
// ----------------------------------------------------------------------------
// box_pair_overlap_test_core
// Oriented and world-aligned overlap test for a pair of rotated rectangles.
// ----------------------------------------------------------------------------
// Each req transaction carries two boxes (center Q15.8, cos/sin Q1.14, half
// extents Q15.8); each rsp transaction returns the separating-axis hit over
// the four box axes, the strict bounding-box hit and the rounded, saturated
// bounding-box overlap in x and y. The core takes one pair per clock while
// req_tready is high and returns each result through the six-stage
// multiply/add pipeline (trig products, dot sums and center projections,
// extent products, axis sums and bounds, compares, rounding). Per-stage
// valid bits let bubbles close up while rsp_tready is low; req_tready drops
// only when all six stages hold a transaction. No state survives a pair.
`include "box_pair_overlap_test_core_assert.svh"

module box_pair_overlap_test_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_center_x, a_center_y, a_cosine, a_sine, a_half_width, a_half_height,
   // b_center_x, b_center_y, b_cosine, b_sine, b_half_width, b_half_height
   input  logic [bpot_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // oriented_hit, aligned_hit, overlap_x, overlap_y
   output logic [bpot_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int NS = bpot_pkg::NUM_STAGES;
   localparam int FS = bpot_pkg::FRAC_SHIFT;

   logic [NS:1] vld_ff, vld_in, stage_en;

   bpot_pkg::box_type box_a, box_b;
   bpot_pkg::s1_type  s1_ff, s1_in;
   bpot_pkg::s2_type  s2_ff, s2_in;
   bpot_pkg::s3_type  s3_ff, s3_in;
   bpot_pkg::s4_type  s4_ff, s4_in;
   bpot_pkg::s5_type  s5_ff, s5_in;
   bpot_pkg::s6_type  s6_ff, s6_in;

   logic signed [bpot_pkg::DOT_W:0]  a_norm_sum, b_norm_sum, dot_p_sum, dot_q_sum;
   logic signed [bpot_pkg::DIST_W:0] dist_ar, dist_au, dist_br, dist_bu;
   logic signed [bpot_pkg::BOUND_W-1:0] a_cx_scl, a_cy_scl, b_cx_scl, b_cy_scl;
   logic signed [bpot_pkg::BOUND_W-1:0] min_right, max_left, min_top, max_bottom;

   // ---- flow control: a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[NS] = !vld_ff[NS] || rsp_tready;
      for (int k = NS - 1; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in = {vld_ff[NS-1:1], req_tvalid};
   end

   assign req_tready = stage_en[1];
   assign rsp_tvalid = vld_ff[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // ---- stage 1: trig products, center deltas
   always_comb begin
      box_a = bpot_pkg::unpack_box(req_tdata[bpot_pkg::BOX_W-1:0]);
      box_b = bpot_pkg::unpack_box(req_tdata[2*bpot_pkg::BOX_W-1:bpot_pkg::BOX_W]);
      s1_in.sq_ac     = box_a.cosine * box_a.cosine;
      s1_in.sq_as     = box_a.sine * box_a.sine;
      s1_in.sq_bc     = box_b.cosine * box_b.cosine;
      s1_in.sq_bs     = box_b.sine * box_b.sine;
      s1_in.pr_acbc   = box_a.cosine * box_b.cosine;
      s1_in.pr_asbs   = box_a.sine * box_b.sine;
      s1_in.pr_acbs   = box_a.cosine * box_b.sine;
      s1_in.pr_asbc   = box_a.sine * box_b.cosine;
      s1_in.dx        = bpot_pkg::DIFF_W'(box_a.cx) - bpot_pkg::DIFF_W'(box_b.cx);
      s1_in.dy        = bpot_pkg::DIFF_W'(box_a.cy) - bpot_pkg::DIFF_W'(box_b.cy);
      s1_in.a_cos     = box_a.cosine;
      s1_in.a_sin     = box_a.sine;
      s1_in.b_cos     = box_b.cosine;
      s1_in.b_sin     = box_b.sine;
      s1_in.a_cos_mag = bpot_pkg::mag_trig(box_a.cosine);
      s1_in.a_sin_mag = bpot_pkg::mag_trig(box_a.sine);
      s1_in.b_cos_mag = bpot_pkg::mag_trig(box_b.cosine);
      s1_in.b_sin_mag = bpot_pkg::mag_trig(box_b.sine);
      s1_in.a_hw      = box_a.hw;
      s1_in.a_hh      = box_a.hh;
      s1_in.b_hw      = box_b.hw;
      s1_in.b_hh      = box_b.hh;
      s1_in.a_cx      = box_a.cx;
      s1_in.a_cy      = box_a.cy;
      s1_in.b_cx      = box_b.cx;
      s1_in.b_cy      = box_b.cy;
   end

   // ---- stage 2: axis dot magnitudes, center projections, bbox products
   // Dots between box axes reduce to |a|^2, |b|^2, p = ar.br and q = ar.bu;
   // au.br = -q and au.bu = p.
   always_comb begin
      a_norm_sum = (bpot_pkg::DOT_W+1)'(s1_ff.sq_ac) + (bpot_pkg::DOT_W+1)'(s1_ff.sq_as);
      b_norm_sum = (bpot_pkg::DOT_W+1)'(s1_ff.sq_bc) + (bpot_pkg::DOT_W+1)'(s1_ff.sq_bs);
      dot_p_sum  = (bpot_pkg::DOT_W+1)'(s1_ff.pr_acbc) + (bpot_pkg::DOT_W+1)'(s1_ff.pr_asbs);
      dot_q_sum  = (bpot_pkg::DOT_W+1)'(s1_ff.pr_asbc) - (bpot_pkg::DOT_W+1)'(s1_ff.pr_acbs);
      s2_in.a_norm   = a_norm_sum[bpot_pkg::DOT_W-1:0];
      s2_in.b_norm   = b_norm_sum[bpot_pkg::DOT_W-1:0];
      s2_in.dot_p    = bpot_pkg::mag_dot(dot_p_sum);
      s2_in.dot_q    = bpot_pkg::mag_dot(dot_q_sum);
      s2_in.cp_ac_dx = s1_ff.a_cos * s1_ff.dx;
      s2_in.cp_as_dy = s1_ff.a_sin * s1_ff.dy;
      s2_in.cp_ac_dy = s1_ff.a_cos * s1_ff.dy;
      s2_in.cp_as_dx = s1_ff.a_sin * s1_ff.dx;
      s2_in.cp_bc_dx = s1_ff.b_cos * s1_ff.dx;
      s2_in.cp_bs_dy = s1_ff.b_sin * s1_ff.dy;
      s2_in.cp_bc_dy = s1_ff.b_cos * s1_ff.dy;
      s2_in.cp_bs_dx = s1_ff.b_sin * s1_ff.dx;
      s2_in.bp_a_cw  = s1_ff.a_cos_mag * s1_ff.a_hw;
      s2_in.bp_a_sh  = s1_ff.a_sin_mag * s1_ff.a_hh;
      s2_in.bp_a_sw  = s1_ff.a_sin_mag * s1_ff.a_hw;
      s2_in.bp_a_ch  = s1_ff.a_cos_mag * s1_ff.a_hh;
      s2_in.bp_b_cw  = s1_ff.b_cos_mag * s1_ff.b_hw;
      s2_in.bp_b_sh  = s1_ff.b_sin_mag * s1_ff.b_hh;
      s2_in.bp_b_sw  = s1_ff.b_sin_mag * s1_ff.b_hw;
      s2_in.bp_b_ch  = s1_ff.b_cos_mag * s1_ff.b_hh;
      s2_in.a_hw     = s1_ff.a_hw;
      s2_in.a_hh     = s1_ff.a_hh;
      s2_in.b_hw     = s1_ff.b_hw;
      s2_in.b_hh     = s1_ff.b_hh;
      s2_in.a_cx     = s1_ff.a_cx;
      s2_in.a_cy     = s1_ff.a_cy;
      s2_in.b_cx     = s1_ff.b_cx;
      s2_in.b_cy     = s1_ff.b_cy;
   end

   // ---- stage 3: projected extent products, center distances, bbox extents
   always_comb begin
      dist_ar = (bpot_pkg::DIST_W+1)'(s2_ff.cp_ac_dx) + (bpot_pkg::DIST_W+1)'(s2_ff.cp_as_dy);
      dist_au = (bpot_pkg::DIST_W+1)'(s2_ff.cp_ac_dy) - (bpot_pkg::DIST_W+1)'(s2_ff.cp_as_dx);
      dist_br = (bpot_pkg::DIST_W+1)'(s2_ff.cp_bc_dx) + (bpot_pkg::DIST_W+1)'(s2_ff.cp_bs_dy);
      dist_bu = (bpot_pkg::DIST_W+1)'(s2_ff.cp_bc_dy) - (bpot_pkg::DIST_W+1)'(s2_ff.cp_bs_dx);
      s3_in.e_ar_a  = s2_ff.a_norm * s2_ff.a_hw;
      s3_in.e_ar_bw = s2_ff.dot_p * s2_ff.b_hw;
      s3_in.e_ar_bh = s2_ff.dot_q * s2_ff.b_hh;
      s3_in.e_au_a  = s2_ff.a_norm * s2_ff.a_hh;
      s3_in.e_au_bw = s2_ff.dot_q * s2_ff.b_hw;
      s3_in.e_au_bh = s2_ff.dot_p * s2_ff.b_hh;
      s3_in.e_br_aw = s2_ff.dot_p * s2_ff.a_hw;
      s3_in.e_br_ah = s2_ff.dot_q * s2_ff.a_hh;
      s3_in.e_br_b  = s2_ff.b_norm * s2_ff.b_hw;
      s3_in.e_bu_aw = s2_ff.dot_q * s2_ff.a_hw;
      s3_in.e_bu_ah = s2_ff.dot_p * s2_ff.a_hh;
      s3_in.e_bu_b  = s2_ff.b_norm * s2_ff.b_hh;
      s3_in.ctr_dist[0] = bpot_pkg::mag_dist(dist_ar);
      s3_in.ctr_dist[1] = bpot_pkg::mag_dist(dist_au);
      s3_in.ctr_dist[2] = bpot_pkg::mag_dist(dist_br);
      s3_in.ctr_dist[3] = bpot_pkg::mag_dist(dist_bu);
      s3_in.a_ext_x = bpot_pkg::BEXT_W'(s2_ff.bp_a_cw) + bpot_pkg::BEXT_W'(s2_ff.bp_a_sh);
      s3_in.a_ext_y = bpot_pkg::BEXT_W'(s2_ff.bp_a_sw) + bpot_pkg::BEXT_W'(s2_ff.bp_a_ch);
      s3_in.b_ext_x = bpot_pkg::BEXT_W'(s2_ff.bp_b_cw) + bpot_pkg::BEXT_W'(s2_ff.bp_b_sh);
      s3_in.b_ext_y = bpot_pkg::BEXT_W'(s2_ff.bp_b_sw) + bpot_pkg::BEXT_W'(s2_ff.bp_b_ch);
      s3_in.a_cx    = s2_ff.a_cx;
      s3_in.a_cy    = s2_ff.a_cy;
      s3_in.b_cx    = s2_ff.b_cx;
      s3_in.b_cy    = s2_ff.b_cy;
   end

   // ---- stage 4: summed reach per axis, world bounds at Q.22
   always_comb begin
      a_cx_scl = bpot_pkg::BOUND_W'($signed({s3_ff.a_cx, {FS{1'b0}}}));
      a_cy_scl = bpot_pkg::BOUND_W'($signed({s3_ff.a_cy, {FS{1'b0}}}));
      b_cx_scl = bpot_pkg::BOUND_W'($signed({s3_ff.b_cx, {FS{1'b0}}}));
      b_cy_scl = bpot_pkg::BOUND_W'($signed({s3_ff.b_cy, {FS{1'b0}}}));
      s4_in.ctr_dist = s3_ff.ctr_dist;
      s4_in.reach[0] = bpot_pkg::ESUM_W'(s3_ff.e_ar_a) + bpot_pkg::ESUM_W'(s3_ff.e_ar_bw)
                     + bpot_pkg::ESUM_W'(s3_ff.e_ar_bh);
      s4_in.reach[1] = bpot_pkg::ESUM_W'(s3_ff.e_au_a) + bpot_pkg::ESUM_W'(s3_ff.e_au_bw)
                     + bpot_pkg::ESUM_W'(s3_ff.e_au_bh);
      s4_in.reach[2] = bpot_pkg::ESUM_W'(s3_ff.e_br_aw) + bpot_pkg::ESUM_W'(s3_ff.e_br_ah)
                     + bpot_pkg::ESUM_W'(s3_ff.e_br_b);
      s4_in.reach[3] = bpot_pkg::ESUM_W'(s3_ff.e_bu_aw) + bpot_pkg::ESUM_W'(s3_ff.e_bu_ah)
                     + bpot_pkg::ESUM_W'(s3_ff.e_bu_b);
      s4_in.a_right  = a_cx_scl + bpot_pkg::BOUND_W'(s3_ff.a_ext_x);
      s4_in.a_left   = a_cx_scl - bpot_pkg::BOUND_W'(s3_ff.a_ext_x);
      s4_in.a_top    = a_cy_scl + bpot_pkg::BOUND_W'(s3_ff.a_ext_y);
      s4_in.a_bottom = a_cy_scl - bpot_pkg::BOUND_W'(s3_ff.a_ext_y);
      s4_in.b_right  = b_cx_scl + bpot_pkg::BOUND_W'(s3_ff.b_ext_x);
      s4_in.b_left   = b_cx_scl - bpot_pkg::BOUND_W'(s3_ff.b_ext_x);
      s4_in.b_top    = b_cy_scl + bpot_pkg::BOUND_W'(s3_ff.b_ext_y);
      s4_in.b_bottom = b_cy_scl - bpot_pkg::BOUND_W'(s3_ff.b_ext_y);
   end

   // ---- stage 5: strict separation per axis, raw overlaps
   always_comb begin
      for (int k = 0; k < bpot_pkg::NUM_AXES; k++) begin
         s5_in.sep[k] = bpot_pkg::ESUM_W'({s4_ff.ctr_dist[k], {FS{1'b0}}}) > s4_ff.reach[k];
      end
      min_right  = (s4_ff.a_right < s4_ff.b_right) ? s4_ff.a_right : s4_ff.b_right;
      max_left   = (s4_ff.a_left > s4_ff.b_left) ? s4_ff.a_left : s4_ff.b_left;
      min_top    = (s4_ff.a_top < s4_ff.b_top) ? s4_ff.a_top : s4_ff.b_top;
      max_bottom = (s4_ff.a_bottom > s4_ff.b_bottom) ? s4_ff.a_bottom : s4_ff.b_bottom;
      s5_in.ovl_x = bpot_pkg::OVL_RAW_W'(min_right) - bpot_pkg::OVL_RAW_W'(max_left);
      s5_in.ovl_y = bpot_pkg::OVL_RAW_W'(min_top) - bpot_pkg::OVL_RAW_W'(max_bottom);
   end

   // ---- stage 6: hits, rounding to Q17.8, output register
   always_comb begin
      s6_in.oriented_hit = ~|s5_ff.sep;
      s6_in.aligned_hit  = !s5_ff.ovl_x[bpot_pkg::OVL_RAW_W-1] && (s5_ff.ovl_x != '0)
                        && !s5_ff.ovl_y[bpot_pkg::OVL_RAW_W-1] && (s5_ff.ovl_y != '0);
      s6_in.overlap_x    = bpot_pkg::round_sat(s5_ff.ovl_x);
      s6_in.overlap_y    = bpot_pkg::round_sat(s5_ff.ovl_y);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_ff <= s1_in;
      end
      if (stage_en[2]) begin
         s2_ff <= s2_in;
      end
      if (stage_en[3]) begin
         s3_ff <= s3_in;
      end
      if (stage_en[4]) begin
         s4_ff <= s4_in;
      end
      if (stage_en[5]) begin
         s5_ff <= s5_in;
      end
      if (stage_en[6]) begin
         s6_ff <= s6_in;
      end
   end

   assign rsp_tdata = {{bpot_pkg::RSP_PAD_W{1'b0}}, s6_ff.overlap_y, s6_ff.overlap_x,
                       s6_ff.aligned_hit, s6_ff.oriented_hit};

   // ---- assertions
   `BPOT_ASSERT_IMP(a_ready_low_only_when_full, clock, reset, !req_tready, &vld_ff,
      "req_tready low with a free pipeline stage")
   `BPOT_ASSERT_IMP(a_aligned_overlap_nonneg, clock, reset,
      rsp_tvalid && s6_ff.aligned_hit,
      !s6_ff.overlap_x[bpot_pkg::OVL_W-1] && !s6_ff.overlap_y[bpot_pkg::OVL_W-1],
      "aligned hit with a negative overlap")
   `BPOT_ASSERT_NXT(a_empty_after_reset, clock, 1'b0, reset, vld_ff == '0,
      "pipeline not empty after reset")
   `BPOT_ASSERT_NXT(a_blocked_stage_holds, clock, reset, vld_ff[3] && !stage_en[3],
      vld_ff[3], "blocked stage lost its transaction")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for box_pair_overlap_test_core. Box pairs go in on the
// req stream, and each is scored by an in-bench fixed-point predictor that
// runs the separating-axis and bounding-box math. Every rsp transaction is
// compared field by field against the oldest predicted result. Stimulus is
// directed corners followed by random raw, grid-aligned and nearby pairs, with random
// stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int     OVL_W       = bpot_pkg::OVL_W;
   localparam int     POS_W       = bpot_pkg::POS_W;
   localparam int     TRIG_W      = bpot_pkg::TRIG_W;
   localparam int     EXT_W       = bpot_pkg::EXT_W;
   localparam int     FRAC_SHIFT  = bpot_pkg::FRAC_SHIFT;
   localparam longint FRAC_SCALE  = 64'sd1 << FRAC_SHIFT;
   localparam longint OVL_HI      = 33554431;
   localparam longint OVL_LO      = -33554432;
   localparam int     CYCLE_LIMIT = 500000;
   localparam int     IDLE_MAX    = 12;

   typedef struct {
      logic                    oriented_hit;
      logic                    aligned_hit;
      logic signed [OVL_W-1:0] overlap_x;
      logic signed [OVL_W-1:0] overlap_y;
   } overlap_result_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [bpot_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [bpot_pkg::RSP_DATA_W-1:0]     rsp_tdata;

   overlap_result_type pending_results[$];
   int unsigned     send_idle_max  = 0;
   int unsigned     recv_idle_max  = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     pairs_sent     = 0;
   int unsigned     results_seen   = 0;
   int unsigned     oriented_hits  = 0;
   int unsigned     aligned_hits   = 0;
   int unsigned     clamped_count  = 0;

   box_pair_overlap_test_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Fixed-point predictor
   // ---------------------------------------------------------------------
   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // half extent of a box projected on an unnormalized axis, Q.36
   function automatic longint axis_reach(input bpot_pkg::box_type bx, input longint lx,
                                         input longint ly);
      longint c, s;
      c = $signed(bx.cosine);
      s = $signed(bx.sine);
      return mag(lx * c + ly * s) * longint'(bx.hw) +
             mag(ly * c - lx * s) * longint'(bx.hh);
   endfunction

   function automatic bit axis_separates(input longint lx, input longint ly,
                                         input bpot_pkg::box_type a,
                                         input bpot_pkg::box_type b);
      longint dx, dy, ctr_dist;
      dx       = longint'($signed(a.cx)) - longint'($signed(b.cx));
      dy       = longint'($signed(a.cy)) - longint'($signed(b.cy));
      ctr_dist = mag(lx * dx + ly * dy);
      return ctr_dist * FRAC_SCALE > axis_reach(a, lx, ly) + axis_reach(b, lx, ly);
   endfunction

   // Q.22 to Q17.8, nearest with ties up, then clamp
   function automatic logic signed [OVL_W-1:0] round_clamp(input longint v);
      longint q;
      q = (v + FRAC_SCALE / 2) >>> FRAC_SHIFT;
      if (q > OVL_HI) q = OVL_HI;
      if (q < OVL_LO) q = OVL_LO;
      return q[OVL_W-1:0];
   endfunction

   function automatic overlap_result_type predict_overlap(input bpot_pkg::box_type a,
                                                          input bpot_pkg::box_type b);
      overlap_result_type r;
      longint ac, as, bc, bs, aex, aey, bex, bey;
      longint acx, acy, bcx, bcy, min_r, max_l, min_t, max_b, ox, oy;
      ac  = $signed(a.cosine);
      as  = $signed(a.sine);
      bc  = $signed(b.cosine);
      bs  = $signed(b.sine);
      acx = longint'($signed(a.cx)) * FRAC_SCALE;
      acy = longint'($signed(a.cy)) * FRAC_SCALE;
      bcx = longint'($signed(b.cx)) * FRAC_SCALE;
      bcy = longint'($signed(b.cy)) * FRAC_SCALE;
      r.oriented_hit = !(axis_separates(ac, as, a, b) || axis_separates(-as, ac, a, b) ||
                         axis_separates(bc, bs, a, b) || axis_separates(-bs, bc, a, b));
      aex = mag(ac) * longint'(a.hw) + mag(as) * longint'(a.hh);
      aey = mag(as) * longint'(a.hw) + mag(ac) * longint'(a.hh);
      bex = mag(bc) * longint'(b.hw) + mag(bs) * longint'(b.hh);
      bey = mag(bs) * longint'(b.hw) + mag(bc) * longint'(b.hh);
      min_r = (acx + aex < bcx + bex) ? acx + aex : bcx + bex;
      max_l = (acx - aex > bcx - bex) ? acx - aex : bcx - bex;
      min_t = (acy + aey < bcy + bey) ? acy + aey : bcy + bey;
      max_b = (acy - aey > bcy - bey) ? acy - aey : bcy - bey;
      ox = min_r - max_l;
      oy = min_t - max_b;
      r.aligned_hit = (ox > 0) && (oy > 0);
      r.overlap_x   = round_clamp(ox);
      r.overlap_y   = round_clamp(oy);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic bpot_pkg::box_type mk_box(input int cx, input int cy, input int c,
                                                input int s, input int hw, input int hh);
      bpot_pkg::box_type bx;
      bx.cx     = POS_W'(cx);
      bx.cy     = POS_W'(cy);
      bx.cosine = TRIG_W'(c);
      bx.sine   = TRIG_W'(s);
      bx.hw     = EXT_W'(hw);
      bx.hh     = EXT_W'(hh);
      return bx;
   endfunction

   task automatic send_box_pair(input bpot_pkg::box_type a, input bpot_pkg::box_type b);
      overlap_result_type want;
      int unsigned     gap;
      want = predict_overlap(a, b);
      gap  = $urandom_range(send_idle_max, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      // tdata fields from bit 0 up: box A then box B, each cx, cy, cos, sin, hw, hh
      req_tdata  <= bpot_pkg::REQ_DATA_W'({b.hh, b.hw, b.sine, b.cosine, b.cy, b.cx,
                                           a.hh, a.hw, a.sine, a.cosine, a.cy, a.cx});
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_results.push_back(want);
      pairs_sent++;
      if (want.oriented_hit) oriented_hits++;
      if (want.aligned_hit) aligned_hits++;
      if (want.overlap_x == OVL_HI || want.overlap_y == OVL_HI) clamped_count++;
      @(negedge clock);
   endtask

   // hold off the req stream until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic pick_trig(output logic signed [TRIG_W-1:0] c,
                            output logic signed [TRIG_W-1:0] s);
      real         ang;
      int unsigned sel;
      sel = $urandom_range(9, 0);
      if (sel < 7) begin
         ang = real'($urandom_range(3599, 0)) * 3.14159265358979 / 1800.0;
         c   = TRIG_W'($rtoi($floor(16384.0 * $cos(ang) + 0.5)));
         s   = TRIG_W'($rtoi($floor(16384.0 * $sin(ang) + 0.5)));
      end else if (sel < 9) begin
         c = TRIG_W'($urandom);
         s = TRIG_W'($urandom);
      end else begin
         case ($urandom_range(4, 0))
            0: c = 16'sd0;
            1: c = 16'sd16384;
            2: c = -16'sd16384;
            3: c = 16'sh7FFF;
            default: c = 16'sh8000;
         endcase
         s = ($urandom_range(1, 0) == 0) ? 16'sd0 : TRIG_W'($urandom);
      end
   endtask

   task automatic make_random_pair(output bpot_pkg::box_type a,
                                   output bpot_pkg::box_type b);
      int unsigned kind, ext_max;
      int          span;
      kind = $urandom_range(9, 0);
      if (kind < 2) begin
         // raw noise, every bit free
         a = bpot_pkg::BOX_W'({$urandom, $urandom, $urandom, $urandom});
         b = bpot_pkg::BOX_W'({$urandom, $urandom, $urandom, $urandom});
      end else if (kind == 9) begin
         // axis-aligned, offsets and extents on the Q15.8 integer grid, so edges often just touch
         a = mk_box($urandom, $urandom, 16384, 0, 256 * $urandom_range(4, 0),
                    256 * $urandom_range(4, 0));
         b = mk_box(int'(a.cx) + 256 * (int'($urandom_range(8, 0)) - 4),
                    int'(a.cy) + 256 * (int'($urandom_range(8, 0)) - 4),
                    0, ($urandom_range(1, 0) == 0) ? 16384 : -16384,
                    256 * $urandom_range(4, 0), 256 * $urandom_range(4, 0));
      end else begin
         // nearby pair, mostly small extents, a few huge ones
         ext_max = (kind == 8) ? (1 << 22) : ((kind < 5) ? (1 << 10) : (1 << 14));
         span    = 3 * int'(ext_max);
         a.cx = POS_W'($urandom);
         a.cy = POS_W'($urandom);
         a.hw = EXT_W'($urandom_range(ext_max, 0));
         a.hh = EXT_W'($urandom_range(ext_max, 0));
         b.cx = a.cx + POS_W'(int'($urandom_range(2 * span, 0)) - span);
         b.cy = a.cy + POS_W'(int'($urandom_range(2 * span, 0)) - span);
         b.hw = EXT_W'($urandom_range(ext_max, 0));
         b.hh = EXT_W'($urandom_range(ext_max, 0));
         pick_trig(a.cosine, a.sine);
         pick_trig(b.cosine, b.sine);
      end
   endtask

   task automatic run_random_pairs(input int unsigned count);
      bpot_pkg::box_type a, b;
      repeat (count) begin
         make_random_pair(a, b);
         send_box_pair(a, b);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_corners();
      send_idle_max = 0;
      recv_idle_max = 0;
      // two points at the origin
      send_box_pair(mk_box(0, 0, 0, 0, 0, 0), mk_box(0, 0, 0, 0, 0, 0));
      send_box_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(0, 0, 16384, 0, 256, 256));
      // edges touching in x, then one lsb apart
      send_box_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(512, 0, 16384, 0, 256, 256));
      send_box_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(513, 0, 16384, 0, 256, 256));
      send_box_pair(mk_box(0, 0, 11585, 11585, 1024, 512),
                    mk_box(1800, 0, 11585, -11585, 1024, 512));
      // thin parallel diagonals: bounds overlap, an oriented axis separates
      send_box_pair(mk_box(0, 0, 11585, 11585, 4096, 64),
                    mk_box(-724, 724, 11585, 11585, 4096, 64));
      // field maxima, positive saturation
      send_box_pair(mk_box(8388607, 8388607, 32767, 32767, 8388607, 8388607),
                    mk_box(-8388608, -8388608, -32768, -32768, 8388607, 8388607));
      send_box_pair(mk_box(-8388608, -8388608, -32768, -32768, 0, 0),
                    mk_box(8388607, 8388607, 32767, -32768, 0, 0));
      // zero-length axes on one box, then on both
      send_box_pair(mk_box(0, 0, 0, 0, 1000, 1000), mk_box(100000, 0, 16384, 0, 10, 10));
      send_box_pair(mk_box(0, 0, 0, 0, 1000, 1000), mk_box(500000, 0, 0, 0, 50, 50));
      // overlap exactly half an lsb below and above zero
      send_box_pair(mk_box(0, 0, 8192, 0, 1, 0), mk_box(1, 0, 16384, 0, 0, 0));
      send_box_pair(mk_box(0, 0, 8192, 0, 1, 0), mk_box(1, 0, 16384, 0, 1, 0));
      // overlap in x only
      send_box_pair(mk_box(0, 0, 16384, 0, 512, 256), mk_box(100, 2000, 16384, 0, 512, 256));
      // unnormalized trig at twice unit length
      send_box_pair(mk_box(0, 0, 32767, 0, 256, 256), mk_box(700, 300, 0, 32767, 256, 128));
      // B inside A, then quarter turns, half turns and unnormalized extremes
      send_box_pair(mk_box(0, 0, 16384, 0, 4096, 4096), mk_box(100, -100, 0, 16384, 64, 32));
      send_box_pair(mk_box(-5000, 0, 0, -16384, 2048, 512),
                    mk_box(-5000, 1800, -16384, 0, 512, 512));
      send_box_pair(mk_box(-8388608, 8388607, -16384, 0, 8388607, 0),
                    mk_box(8388607, -8388608, 0, -16384, 0, 8388607));
      send_box_pair(mk_box(8388607, -8388608, -32768, 32767, 1, 8388607),
                    mk_box(-8388608, 8388607, 32767, -32768, 8388607, 1));
   endtask

   task automatic test_back_to_back();
      send_idle_max = 0;
      recv_idle_max = 0;
      run_random_pairs(300);
   endtask

   task automatic test_drain_and_resume();
      send_idle_max = IDLE_MAX;
      recv_idle_max = IDLE_MAX;
      run_random_pairs(40);
      drain_results();
      run_random_pairs(40);
   endtask

   task automatic test_receiver_stalls();
      send_idle_max = 0;
      recv_idle_max = IDLE_MAX;
      run_random_pairs(200);
   endtask

   task automatic test_sender_gaps();
      send_idle_max = IDLE_MAX;
      recv_idle_max = 0;
      run_random_pairs(200);
   endtask

   task automatic test_random_idling();
      send_idle_max = IDLE_MAX;
      recv_idle_max = IDLE_MAX;
      run_random_pairs(1150);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   initial begin : drive_rsp_ready
      int unsigned stall;
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(recv_idle_max, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // rsp_tdata fields from bit 0 up: oriented_hit, aligned_hit, overlap_x, overlap_y
   always @(posedge clock) begin : check_results
      overlap_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("rsp transaction with no pair outstanding: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            check_field("oriented_hit", want.oriented_hit, rsp_tdata[0]);
            check_field("aligned_hit", want.aligned_hit, rsp_tdata[1]);
            check_field("overlap_x", want.overlap_x, $signed(rsp_tdata[OVL_W+1:2]));
            check_field("overlap_y", want.overlap_y,
                        $signed(rsp_tdata[2*OVL_W+1:OVL_W+2]));
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_corners();
      test_back_to_back();
      test_drain_and_resume();
      test_receiver_stalls();
      test_sender_gaps();
      test_random_idling();
      drain_results();
      repeat (bpot_pkg::NUM_STAGES + 4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d predicted results never arrived", pending_results.size());
         mismatch_count++;
      end
      $display("Ran %0d box pairs (corners, near, far, raw and grid-aligned), %0d results checked",
               pairs_sent, results_seen);
      $display("with %0d oriented hits, %0d aligned hits, %0d clamped overlaps",
               oriented_hits, aligned_hits, clamped_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
